### src/rtp_jitter_reorder_buffer_core_assert.svh
// Assertion macros for the jitter buffer RTL.
// No dependencies; included by modules that carry assertions.
`ifndef RTP_JITTER_REORDER_BUFFER_CORE_ASSERT_SVH
`define RTP_JITTER_REORDER_BUFFER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RJB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jitter buffer assertion failed");

// Next-cycle implication, disabled in reset.
`define RJB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jitter buffer assertion failed");

`endif

### src/rjb_pkg.sv
// Package for the jitter reorder buffer: widths, codes and the cell command.
// No dependencies.
`default_nettype none

package rjb_pkg;

    localparam int CAPACITY_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int SEQ_W            = 16;
    localparam int CNT_W            = 7;
    localparam int TIMER_W          = 16;

    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] REG_MAX_PACKETS  = 2'd0;
    localparam logic [1:0] REG_MIN_BUFFERED = 2'd1;
    localparam logic [1:0] REG_GAP_TIMEOUT  = 2'd2;

    localparam logic [2:0] OP_HOLD   = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_SHIFT  = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    typedef struct packed {
        logic [2:0]       op;
        logic [SEQ_W-1:0] key;
    } cell_cmd_t;

endpackage

`default_nettype wire

### src/rtp_jitter_reorder_buffer_core.sv
// Top level of the jitter reorder buffer: control, registers, cell chain.
// Depends on rjb_pkg, rjb_cell and rtp_jitter_reorder_buffer_core_assert.svh.
`default_nettype none
`include "rtp_jitter_reorder_buffer_core_assert.svh"

// Usage
//   Request channel: drive kind, seq_in and payload_in and raise start; the
//   request is taken at a rising edge where start is high and busy is low.
//   Each request gives exactly one result, shown for one cycle with done high
//   (popped, seq_out, payload_out, evicted, occupancy). The receiver cannot
//   stall; sample the result on that cycle.
//   The accepting edge enters S_EVAL, which registers the result with done for
//   every request but a push into a buffer already holding max_packets entries
//   with a number above the smallest; that push passes S_EVAL and then S_INS
//   (drop the head, then insert). busy drops as done rises, so a new request
//   may be taken on the done cycle, and none is taken while one is in flight.
//   The cell chain does one shift (insert, remove or drop head) per cycle.
//   Entries live in a chain of CAPACITY cells kept sorted ascending by
//   sequence number and packed from cell 0, so cell 0 holds the smallest.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
//   while idle. Index 0 max_packets, 1 min_buffered, 2 gap_timeout; others
//   are ignored. Lower max_packets only after a clear request.
//   Reset: empties the chain, forgets playout state, loads 64, 3 and 20 (first two clamped to CAPACITY).
module rtp_jitter_reorder_buffer_core #(
    parameter int CAPACITY     = rjb_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = rjb_pkg::PAYLOAD_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire [1:0]                    kind,
    input  wire [rjb_pkg::SEQ_W-1:0]     seq_in,
    input  wire [PAYLOAD_BITS-1:0]       payload_in,
    output logic                         done,
    output logic                         popped,
    output logic [rjb_pkg::SEQ_W-1:0]    seq_out,
    output logic [PAYLOAD_BITS-1:0]      payload_out,
    output logic                         evicted,
    output logic [rjb_pkg::CNT_W-1:0]    occupancy,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [1:0]                    cfg_index,
    input  wire [rjb_pkg::TIMER_W-1:0]   cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_INS  = 2'd2;

    localparam int CW = rjb_pkg::CNT_W;
    localparam int SW = rjb_pkg::SEQ_W;
    localparam int TW = rjb_pkg::TIMER_W;

    // Reset register values, clamped to the chain length.
    localparam int MAX_RST = (CAPACITY < 64) ? CAPACITY : 64;
    localparam int MIN_RST = (MAX_RST < 3) ? MAX_RST : 3;

    logic [1:0]              state_reg, state_next;
    logic [1:0]              kind_reg;
    logic [SW-1:0]           item_seq_reg;
    logic [PAYLOAD_BITS-1:0] item_pay_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] max_reg, max_next;
    logic [CW-1:0] min_reg, min_next;
    logic [TW-1:0] timeout_reg, timeout_next;
    logic          exp_valid_reg, exp_valid_next;
    logic [SW-1:0] exp_seq_reg, exp_seq_next;
    logic          started_reg, started_next;
    logic          gap_wait_reg, gap_wait_next;
    logic [TW-1:0] gap_elapsed_reg, gap_elapsed_next;

    logic                    done_reg, done_next;
    logic                    popped_reg, popped_next;
    logic [SW-1:0]           seq_out_reg, seq_out_next;
    logic [PAYLOAD_BITS-1:0] pay_out_reg, pay_out_next;
    logic                    evicted_reg, evicted_next;
    logic [CW-1:0]           occ_reg, occ_next;

    rjb_pkg::cell_cmd_t cmd;

    logic                    c_valid [CAPACITY];
    logic [SW-1:0]           c_seq   [CAPACITY];
    logic [PAYLOAD_BITS-1:0] c_pay   [CAPACITY];
    logic                    c_pos   [CAPACITY];
    logic                    c_eq    [CAPACITY];

    logic                    any_eq;
    logic [SW-1:0]           eq_seq;
    logic [PAYLOAD_BITS-1:0] eq_pay;
    logic                    ready_pop;
    logic [CW-1:0]           cfg_val;
    logic [CW-1:0]           clamped_max;

    // Chain of cells; cell 0 sees an empty, non-moving left neighbour and the
    // last cell an empty right neighbour.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                    lv, lp, rv;
            logic [SW-1:0]           ls, rs;
            logic [PAYLOAD_BITS-1:0] lpay, rpay;
            if (gi == 0)
            begin : g_first
                assign lv   = 1'b0;
                assign lp   = 1'b0;
                assign ls   = '0;
                assign lpay = '0;
            end
            else
            begin : g_mid_l
                assign lv   = c_valid[gi-1];
                assign lp   = c_pos[gi-1];
                assign ls   = c_seq[gi-1];
                assign lpay = c_pay[gi-1];
            end
            if (gi == CAPACITY-1)
            begin : g_last
                assign rv   = 1'b0;
                assign rs   = '0;
                assign rpay = '0;
            end
            else
            begin : g_mid_r
                assign rv   = c_valid[gi+1];
                assign rs   = c_seq[gi+1];
                assign rpay = c_pay[gi+1];
            end
            rjb_cell #(
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .cmd           (cmd),
                .new_payload   (item_pay_reg),
                .left_valid    (lv),
                .left_seq      (ls),
                .left_payload  (lpay),
                .left_pos      (lp),
                .right_valid   (rv),
                .right_seq     (rs),
                .right_payload (rpay),
                .valid         (c_valid[gi]),
                .seq           (c_seq[gi]),
                .payload       (c_pay[gi]),
                .pos           (c_pos[gi]),
                .eq            (c_eq[gi])
            );
        end
    endgenerate

    // Gather the matching cell; numbers are unique, so at most one matches.
    always_comb
    begin
        any_eq = 1'b0;
        eq_seq = '0;
        eq_pay = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            any_eq = any_eq | c_eq[i];
            eq_seq = eq_seq | (c_eq[i] ? c_seq[i] : '0);
            eq_pay = eq_pay | (c_eq[i] ? c_pay[i] : '0);
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = !busy;
    assign done        = done_reg;
    assign popped      = popped_reg;
    assign seq_out     = seq_out_reg;
    assign payload_out = pay_out_reg;
    assign evicted     = evicted_reg;
    assign occupancy   = occ_reg;

    assign cfg_val = cfg_data[CW-1:0];

    always_comb
    begin
        if (cfg_val == '0)
        begin
            clamped_max = CW'(1);
        end
        else if (32'(cfg_val) > 32'(CAPACITY))
        begin
            clamped_max = CW'(CAPACITY);
        end
        else
        begin
            clamped_max = cfg_val;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        max_next         = max_reg;
        min_next         = min_reg;
        timeout_next     = timeout_reg;
        exp_valid_next   = exp_valid_reg;
        exp_seq_next     = exp_seq_reg;
        started_next     = started_reg;
        gap_wait_next    = gap_wait_reg;
        gap_elapsed_next = gap_elapsed_reg;
        done_next        = 1'b0;
        popped_next      = popped_reg;
        seq_out_next     = seq_out_reg;
        pay_out_next     = pay_out_reg;
        evicted_next     = evicted_reg;
        occ_next         = occ_reg;
        ready_pop        = 1'b0;
        cmd.op           = rjb_pkg::OP_HOLD;
        cmd.key          = item_seq_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next   = S_IDLE;
                done_next    = 1'b1;
                popped_next  = 1'b0;
                seq_out_next = '0;
                pay_out_next = '0;
                evicted_next = 1'b0;
                case (kind_reg)
                    rjb_pkg::KIND_PUSH:
                    begin
                        if (!exp_valid_reg)
                        begin
                            exp_valid_next = 1'b1;
                            exp_seq_next   = item_seq_reg;
                        end
                        if (any_eq)
                        begin
                            cmd.op = rjb_pkg::OP_UPDATE;
                        end
                        else if (count_reg >= max_reg)
                        begin
                            // full: drop the new packet if smallest, else drop head
                            evicted_next = 1'b1;
                            if (item_seq_reg > c_seq[0])
                            begin
                                cmd.op     = rjb_pkg::OP_SHIFT;
                                count_next = count_reg - CW'(1);
                                state_next = S_INS;
                                done_next  = 1'b0;
                            end
                        end
                        else
                        begin
                            cmd.op     = rjb_pkg::OP_INSERT;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    rjb_pkg::KIND_POP:
                    begin
                        cmd.key = exp_seq_reg;
                        if (count_reg != '0)
                        begin
                            if (started_reg || count_reg >= min_reg
                                || count_reg >= max_reg)
                            begin
                                started_next = 1'b1;
                                if (!exp_valid_reg || any_eq)
                                begin
                                    gap_wait_next    = 1'b0;
                                    gap_elapsed_next = '0;
                                    ready_pop        = 1'b1;
                                end
                                else if (count_reg >= max_reg || timeout_reg == '0)
                                begin
                                    ready_pop = 1'b1;
                                end
                                else if (!gap_wait_reg)
                                begin
                                    gap_wait_next    = 1'b1;
                                    gap_elapsed_next = '0;
                                end
                                else
                                begin
                                    ready_pop = (gap_elapsed_reg >= timeout_reg);
                                end
                            end
                        end
                        if (ready_pop)
                        begin
                            popped_next      = 1'b1;
                            exp_valid_next   = 1'b1;
                            gap_wait_next    = 1'b0;
                            gap_elapsed_next = '0;
                            count_next       = count_reg - CW'(1);
                            if (exp_valid_reg && any_eq)
                            begin
                                cmd.op       = rjb_pkg::OP_REMOVE;
                                seq_out_next = eq_seq;
                                pay_out_next = eq_pay;
                                exp_seq_next = eq_seq + SW'(1);
                            end
                            else
                            begin
                                cmd.op       = rjb_pkg::OP_SHIFT;
                                seq_out_next = c_seq[0];
                                pay_out_next = c_pay[0];
                                exp_seq_next = c_seq[0] + SW'(1);
                            end
                        end
                    end
                    rjb_pkg::KIND_TICK:
                    begin
                        if (gap_wait_reg && gap_elapsed_reg != '1)
                        begin
                            gap_elapsed_next = gap_elapsed_reg + TW'(1);
                        end
                    end
                    default:
                    begin
                        cmd.op           = rjb_pkg::OP_CLEAR;
                        count_next       = '0;
                        exp_valid_next   = 1'b0;
                        exp_seq_next     = '0;
                        gap_wait_next    = 1'b0;
                        gap_elapsed_next = '0;
                        started_next     = 1'b0;
                    end
                endcase
                occ_next = count_next;
            end
            S_INS:
            begin
                // second half of an evicting push: head already dropped
                cmd.op       = rjb_pkg::OP_INSERT;
                count_next   = count_reg + CW'(1);
                occ_next     = count_next;
                evicted_next = 1'b1;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rjb_pkg::REG_MAX_PACKETS:
                begin
                    max_next = clamped_max;
                    if (min_reg > clamped_max)
                    begin
                        min_next = clamped_max;
                    end
                end
                rjb_pkg::REG_MIN_BUFFERED:
                begin
                    if (cfg_val > max_reg)
                    begin
                        min_next = max_reg;
                    end
                    else if (cfg_val == '0)
                    begin
                        min_next = CW'(1);
                    end
                    else
                    begin
                        min_next = cfg_val;
                    end
                end
                rjb_pkg::REG_GAP_TIMEOUT:
                begin
                    timeout_next     = cfg_data;
                    gap_wait_next    = 1'b0;
                    gap_elapsed_next = '0;
                end
                default:
                begin
                    timeout_next = timeout_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            max_reg         <= CW'(MAX_RST);
            min_reg         <= CW'(MIN_RST);
            timeout_reg     <= TW'(20);
            exp_valid_reg   <= 1'b0;
            exp_seq_reg     <= '0;
            started_reg     <= 1'b0;
            gap_wait_reg    <= 1'b0;
            gap_elapsed_reg <= '0;
            done_reg        <= 1'b0;
            popped_reg      <= 1'b0;
            evicted_reg     <= 1'b0;
            occ_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            max_reg         <= max_next;
            min_reg         <= min_next;
            timeout_reg     <= timeout_next;
            exp_valid_reg   <= exp_valid_next;
            exp_seq_reg     <= exp_seq_next;
            started_reg     <= started_next;
            gap_wait_reg    <= gap_wait_next;
            gap_elapsed_reg <= gap_elapsed_next;
            done_reg        <= done_next;
            popped_reg      <= popped_next;
            evicted_reg     <= evicted_next;
            occ_reg         <= occ_next;
        end
    end

    // Hold the request and the released data; no reset needed.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg     <= kind;
            item_seq_reg <= seq_in;
            item_pay_reg <= payload_in;
        end
        seq_out_reg <= seq_out_next;
        pay_out_reg <= pay_out_next;
    end

    `RJB_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `RJB_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE)
    `RJB_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= max_reg)
    `RJB_ASSERT_IMP(a_pop_or_evict, clk, rst_n, done_reg, !(popped_reg && evicted_reg))

endmodule

`default_nettype wire

### src/rjb_cell.sv
// One cell of the sorted entry chain: valid flag, sequence number, payload.
// Depends on rjb_pkg.
`default_nettype none

module rjb_cell #(
    parameter int PAYLOAD_BITS = rjb_pkg::PAYLOAD_BITS_DEF
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  rjb_pkg::cell_cmd_t              cmd,
    input  wire [PAYLOAD_BITS-1:0]          new_payload,
    input  wire                             left_valid,
    input  wire [rjb_pkg::SEQ_W-1:0]        left_seq,
    input  wire [PAYLOAD_BITS-1:0]          left_payload,
    input  wire                             left_pos,
    input  wire                             right_valid,
    input  wire [rjb_pkg::SEQ_W-1:0]        right_seq,
    input  wire [PAYLOAD_BITS-1:0]          right_payload,
    output logic                            valid,
    output logic [rjb_pkg::SEQ_W-1:0]       seq,
    output logic [PAYLOAD_BITS-1:0]         payload,
    output logic                            pos,
    output logic                            eq
);

    logic                      valid_reg, valid_next;
    logic [rjb_pkg::SEQ_W-1:0] seq_reg, seq_next;
    logic [PAYLOAD_BITS-1:0]   payload_reg, payload_next;
    logic                      gt;

    assign gt      = valid_reg && (seq_reg > cmd.key);
    assign eq      = valid_reg && (seq_reg == cmd.key);
    assign pos     = !valid_reg || gt;
    assign valid   = valid_reg;
    assign seq     = seq_reg;
    assign payload = payload_reg;

    always_comb
    begin
        valid_next   = valid_reg;
        seq_next     = seq_reg;
        payload_next = payload_reg;
        case (cmd.op)
            rjb_pkg::OP_INSERT:
            begin
                // take the left entry if it moves up too, else the new one
                if (pos)
                begin
                    if (left_pos)
                    begin
                        valid_next   = left_valid;
                        seq_next     = left_seq;
                        payload_next = left_payload;
                    end
                    else
                    begin
                        valid_next   = 1'b1;
                        seq_next     = cmd.key;
                        payload_next = new_payload;
                    end
                end
            end
            rjb_pkg::OP_UPDATE:
            begin
                if (eq)
                begin
                    payload_next = new_payload;
                end
            end
            rjb_pkg::OP_SHIFT:
            begin
                valid_next   = right_valid;
                seq_next     = right_seq;
                payload_next = right_payload;
            end
            rjb_pkg::OP_REMOVE:
            begin
                if (eq || gt)
                begin
                    valid_next   = right_valid;
                    seq_next     = right_seq;
                    payload_next = right_payload;
                end
            end
            rjb_pkg::OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg     <= seq_next;
        payload_reg <= payload_next;
    end

endmodule

`default_nettype wire
